// ----- hdl/pida_pkg.sv -----
`timescale 1ns / 1ps

package pida_pkg;

   localparam int CMD_W    = 2;
   localparam int POS_W    = 8;
   localparam int VALUE_W  = 32;
   localparam int RD_W     = 32;
   localparam int COUNT_W  = 8;
   localparam int STATUS_W = 2;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   localparam int CAPACITY_DEF   = 128;
   localparam int DATA_WIDTH_DEF = 32;

   // cells per registered read group
   localparam int GROUP_SIZE = 16;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_POS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

   typedef struct packed {
      logic ins;
      logic del;
      logic rd;
   } pida_op_type;

endpackage

// ----- hdl/pida_cell.sv -----
`timescale 1ns / 1ps

module pida_cell #(
   parameter int DATA_WIDTH = pida_pkg::DATA_WIDTH_DEF,
   parameter int IDX_W      = pida_pkg::POS_W,
   parameter int INDEX      = 0
) (
   input  logic                    clock,
   input  pida_pkg::pida_op_type   op,
   input  logic [IDX_W-1:0]        pos,
   input  logic [DATA_WIDTH-1:0]   value,
   input  logic [DATA_WIDTH-1:0]   prev_data,
   input  logic [DATA_WIDTH-1:0]   next_data,
   output logic [DATA_WIDTH-1:0]   data,
   output logic [DATA_WIDTH-1:0]   rd_data
);
   import pida_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;
   logic                  at_pos;
   logic                  above_pos;

   assign at_pos    = (pos == MY_IDX);
   assign above_pos = (MY_IDX > pos);

   always_comb begin
      data_in = data_ff;
      if (op.ins && at_pos) begin
         data_in = value;
      end else if (op.ins && above_pos) begin
         data_in = prev_data;
      end else if (op.del && (at_pos || above_pos)) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data    = data_ff;
   assign rd_data = (op.rd && at_pos) ? data_ff : '0;

endmodule

// ----- hdl/pida_chain.sv -----
`timescale 1ns / 1ps

module pida_chain #(
   parameter int CAPACITY   = pida_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = pida_pkg::DATA_WIDTH_DEF,
   parameter int IDX_W      = pida_pkg::POS_W
) (
   input  logic                    clock,
   input  logic                    capture,
   input  pida_pkg::pida_op_type   op,
   input  logic [IDX_W-1:0]        pos,
   input  logic [DATA_WIDTH-1:0]   value,
   output logic [DATA_WIDTH-1:0]   rd_data
);
   import pida_pkg::*;

   localparam int GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int PADDED = GROUPS * GROUP_SIZE;

   logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
   logic [DATA_WIDTH-1:0] cell_rd   [PADDED];
   logic [DATA_WIDTH-1:0] grp_ff    [GROUPS];
   logic [DATA_WIDTH-1:0] grp_in    [GROUPS];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] prev_d;
      logic [DATA_WIDTH-1:0] next_d;

      if (i == 0) begin : g_first
         assign prev_d = '0;
      end else begin : g_mid_prev
         assign prev_d = cell_data[i-1];
      end

      // last cell holds on delete
      if (i == CAPACITY - 1) begin : g_last
         assign next_d = cell_data[i];
      end else begin : g_mid_next
         assign next_d = cell_data[i+1];
      end

      pida_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .IDX_W      (IDX_W),
         .INDEX      (i)
      ) u_cell (
         .clock      (clock),
         .op         (op),
         .pos        (pos),
         .value      (value),
         .prev_data  (prev_d),
         .next_data  (next_d),
         .data       (cell_data[i]),
         .rd_data    (cell_rd[i])
      );
   end

   for (genvar j = CAPACITY; j < PADDED; j++) begin : g_pad
      assign cell_rd[j] = '0;
   end

   // first level of the read gather: OR each group, register the result
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_in[g] = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            grp_in[g] = grp_in[g] | cell_rd[g*GROUP_SIZE + k];
         end
      end
   end

   // hold the gathered word until the next request transfer
   always_ff @(posedge clock) begin
      if (capture) begin
         for (int g = 0; g < GROUPS; g++) begin
            grp_ff[g] <= grp_in[g];
         end
      end
   end

   always_comb begin
      rd_data = '0;
      for (int g = 0; g < GROUPS; g++) begin
         rd_data = rd_data | grp_ff[g];
      end
   end

endmodule

// ----- hdl/positional_insert_delete_array_top.sv -----
`timescale 1ns / 1ps
// After a request transfer the sequencer enters ST_GATHER, and the result goes
// into the output register once that register is free. No new request is taken
// in ST_GATHER. A registered two-level OR gather brings the addressed cell onto the read path.
// Insert and delete shift the cells at and above the position in the transfer cycle.
// Reset (synchronous, active high) clears the live count, the sequencer and the
// output valid; cell contents are not cleared.
module positional_insert_delete_array_top #(
   parameter int CAPACITY   = pida_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = pida_pkg::DATA_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [7:0] position, [39:8] value
   input  logic [pida_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [1:0] command
   input  logic [pida_pkg::CMD_W-1:0]         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [31:0] read_value, [39:32] count
   output logic [pida_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // [1:0] status
   output logic [pida_pkg::STATUS_W-1:0]      rsp_tuser
);
   import pida_pkg::*;

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int IDX_W  = ($clog2(CAPACITY) > POS_W) ? $clog2(CAPACITY) : POS_W;
   localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic {ST_IDLE, ST_GATHER} state_type;

   state_type              state_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic [STATUS_W-1:0]    status_ff;
   logic [STATUS_W-1:0]    status_in;
   logic                   rsp_valid_ff;
   logic [RD_W-1:0]        rsp_value_ff;
   logic [COUNT_W-1:0]     rsp_count_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;

   logic                   accept;
   logic                   out_free;
   logic [CMD_W-1:0]       cmd;
   logic [POS_W-1:0]       position;
   logic [CMP_W-1:0]       pos_cmp;
   logic [CMP_W-1:0]       cnt_cmp;
   logic                   full;
   logic                   ok;
   pida_op_type            op;
   logic [DATA_WIDTH-1:0]  store_value;
   logic [DATA_WIDTH-1:0]  rd_data;

   assign cmd         = req_tuser;
   assign position    = req_tdata[POS_W-1:0];
   assign store_value = DATA_WIDTH'($signed(req_tdata[POS_W +: VALUE_W]));

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign pos_cmp = CMP_W'(position);
   assign cnt_cmp = CMP_W'(count_ff);
   assign full    = (count_ff == CNT_W'(CAPACITY));

   always_comb begin
      status_in = STATUS_OK;
      case (cmd)
         CMD_INSERT: begin
            if (pos_cmp > cnt_cmp) begin
               status_in = STATUS_BAD_POS;
            end else if (full) begin
               status_in = STATUS_FULL;
            end
         end
         CMD_DELETE, CMD_READ: begin
            if (pos_cmp >= cnt_cmp) begin
               status_in = STATUS_BAD_POS;
            end
         end
         default: status_in = STATUS_OK;
      endcase
   end

   assign ok     = accept && (status_in == STATUS_OK);
   assign op.ins = ok && (cmd == CMD_INSERT);
   assign op.del = ok && (cmd == CMD_DELETE);
   assign op.rd  = ok && (cmd == CMD_READ);

   always_comb begin
      count_in = count_ff;
      if (op.ins) begin
         count_in = count_ff + 1'b1;
      end else if (op.del) begin
         count_in = count_ff - 1'b1;
      end
   end

   pida_chain #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IDX_W)
   ) u_chain (
      .clock      (clock),
      .capture    (accept),
      .op         (op),
      .pos        (IDX_W'(position)),
      .value      (store_value),
      .rd_data    (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_GATHER)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  status_ff <= status_in;
                  state_ff  <= ST_GATHER;
               end
            end
            ST_GATHER: begin
               // hold until the output register is free
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_value_ff  <= RD_W'($signed(rd_data));
                  rsp_count_ff  <= COUNT_W'(count_ff);
                  rsp_status_ff <= status_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_count_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ----- hdl/pida_checker.sv -----
`timescale 1ns / 1ps

module pida_checker #(
   parameter int CAPACITY = pida_pkg::CAPACITY_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [pida_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic [pida_pkg::STATUS_W-1:0]      rsp_tuser
);
   import pida_pkg::*;

   // one item in flight: no request transfer straight after another
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while an item is in flight");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == STATUS_OK || rsp_tuser == STATUS_BAD_POS ||
                      rsp_tuser == STATUS_FULL))
      else $error("unknown status code");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != STATUS_OK) |-> (rsp_tdata[RD_W-1:0] == '0))
      else $error("failed item carries a read value");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((CAPACITY > 255) ||
                      (int'(rsp_tdata[RD_W +: COUNT_W]) <= CAPACITY)))
      else $error("count above capacity");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

endmodule

bind positional_insert_delete_array_top pida_checker #(
   .CAPACITY   (CAPACITY)
) u_pida_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
